### rtl/pdzc_pkg.sv
// shared constants of the profile derivative and zero-crossing unit
// no dependencies

package pdzc_pkg;

    localparam int SLOPE_W = 17;
    localparam int CURV_W  = 18;

    // flush sequencer codes, counted down after a last-sample transaction
    localparam logic [1:0] FLUSH_IDLE  = 2'd0;
    localparam logic [1:0] FLUSH_LAST  = 2'd1;
    localparam logic [1:0] FLUSH_MID   = 2'd2;
    localparam logic [1:0] FLUSH_FIRST = 2'd3;

    localparam logic [1:0] SEEN_FULL = 2'd3;

endpackage

### rtl/profile_derivative_zero_crossing_unit.sv
// Usage of profile_derivative_zero_crossing_unit
// Input channel: i_valid / o_stall carry i_sample (signed, SAMPLE_BITS) and
// i_is_last. A transaction happens at a rising edge with i_valid high and
// o_stall low.
// Output channel: o_valid / i_stall carry o_slope (f[i-1]-f[i+1], zeroed
// at sharpened zero crossings), o_curvature_x2 (f[i-1]-2f[i]+f[i+1]) and
// o_final_result. A transaction happens with o_valid high and i_stall low.
// A sequence of n samples gives exactly n results, in order.
// The result for sample i is written into the output register, or into the
// skid register, when sample i+3 is taken (or a flush step stands in for it);
// the tail of a sequence comes out of a flush that the last sample starts.
// Throughput: one sample per cycle while o_stall is low, set by the single
// window update per clock; a last sample starts a flush with o_stall high.
// The output has a register plus a skid register, so a sample is still
// taken while one result waits; o_stall rises only when the skid register
// is occupied or during the flush.
// Reset (i_rst_n low, synchronous) clears the windows, the sample count,
// the flush sequencer and both output valid flags. The window state also
// clears by itself after the final result of a sequence.

module profile_derivative_zero_crossing_unit
    import pdzc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_is_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SLOPE_W-1:0]     o_slope,
    output logic signed [CURV_W-1:0]      o_curvature_x2,
    output logic                          o_final_result
);

    localparam int SB   = SAMPLE_BITS;
    localparam int RW   = SB + 1;  // raw slope width
    localparam int CW   = SB + 2;  // curvature width
    localparam int WIDE = SB + 20;

    // window state
    logic signed [SB-1:0] r_sw0, r_sw1;
    logic signed [RW-1:0] r_raw0, r_raw1;
    logic signed [RW-1:0] r_cur0, r_cur1;
    logic signed [CW-1:0] r_curv0, r_curv1;
    logic                 r_flag0;
    logic [1:0]           r_seen;
    logic [1:0]           r_flush;

    // output register and skid
    logic                     r_out_valid, r_skid_valid;
    logic signed [RW-1:0]     r_out_slope, r_skid_slope;
    logic signed [CW-1:0]     r_out_curv, r_skid_curv;
    logic                     r_out_final, r_skid_final;

    logic                 in_acc, adv, cross_ok, is_final, emit, res_valid, out_take;
    logic signed [SB-1:0] adv_s;
    logic signed [RW-1:0] n_raw;
    logic signed [CW-1:0] n_curv;
    logic signed [CW-1:0] sw1_x, sw0_x, s_x;
    logic                 n_flag;
    logic signed [RW-1:0] n_cur0, n_cur1, res_slope;
    logic [RW-1:0]        mag_old, mag_new;
    logic [1:0]           n_flush;
    logic [1:0]           n_seen;
    logic                 raw_old_pos, raw_new_pos;
    logic signed [WIDE-1:0] slope_wide;
    logic signed [WIDE-1:0] curv_wide;

    assign o_stall  = r_skid_valid || (r_flush != FLUSH_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign adv      = in_acc || ((r_flush != FLUSH_IDLE) && !r_skid_valid);
    assign adv_s    = (r_flush == FLUSH_IDLE) ? i_sample : '0;
    assign cross_ok = (r_flush == FLUSH_IDLE) || (r_flush == FLUSH_FIRST);
    assign is_final = (r_flush == FLUSH_LAST);
    assign emit     = (r_seen == SEEN_FULL);
    assign out_take = r_out_valid && !i_stall;
    assign res_valid = adv && emit;

    always_comb begin
        sw1_x  = {{2{r_sw1[SB-1]}}, r_sw1};
        sw0_x  = {{2{r_sw0[SB-1]}}, r_sw0};
        s_x    = {{2{adv_s[SB-1]}}, adv_s};
        n_raw  = RW'(sw1_x - s_x);
        n_curv = sw1_x - sw0_x - sw0_x + s_x;

        // a slope counts as positive when nonzero and sign clear
        raw_old_pos = !r_raw1[RW-1] && (r_raw1 != '0);
        raw_new_pos = !n_raw[RW-1] && (n_raw != '0);
        n_flag = cross_ok && emit && (raw_old_pos != raw_new_pos);

        mag_old = r_cur1[RW-1] ? RW'(-r_cur1) : RW'(r_cur1);
        mag_new = r_cur0[RW-1] ? RW'(-r_cur0) : RW'(r_cur0);

        res_slope = r_cur1;
        n_cur1    = r_cur0;
        n_cur0    = n_raw;
        // two neighboring crossings: zero the weaker slope, the later one on a tie
        if (r_flag0 && n_flag) begin
            if (mag_old < mag_new) begin
                res_slope = '0;
            end else begin
                n_cur1 = '0;
            end
        end

        n_seen = emit ? r_seen : r_seen + 2'd1;

        n_flush = r_flush;
        if (in_acc && i_is_last) begin
            n_flush = FLUSH_FIRST;
        end else if (adv && (r_flush != FLUSH_IDLE)) begin
            n_flush = r_flush - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && is_final)) begin
            r_sw0   <= '0;
            r_sw1   <= '0;
            r_raw0  <= '0;
            r_raw1  <= '0;
            r_cur0  <= '0;
            r_cur1  <= '0;
            r_curv0 <= '0;
            r_curv1 <= '0;
            r_flag0 <= 1'b0;
            r_seen  <= '0;
        end else if (adv) begin
            r_sw1   <= r_sw0;
            r_sw0   <= adv_s;
            r_raw1  <= r_raw0;
            r_raw0  <= n_raw;
            r_cur1  <= n_cur1;
            r_cur0  <= n_cur0;
            r_curv1 <= r_curv0;
            r_curv0 <= n_curv;
            r_flag0 <= n_flag;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush      <= FLUSH_IDLE;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_flush <= n_flush;
            if (res_valid) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (r_skid_valid && out_take) begin
                r_skid_valid <= 1'b0;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of output register and skid
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out_slope <= res_slope;
                r_out_curv  <= r_curv1;
                r_out_final <= is_final;
            end else begin
                r_skid_slope <= res_slope;
                r_skid_curv  <= r_curv1;
                r_skid_final <= is_final;
            end
        end else if (r_skid_valid && out_take) begin
            r_out_slope <= r_skid_slope;
            r_out_curv  <= r_skid_curv;
            r_out_final <= r_skid_final;
        end
    end

    // outputs keep the low bits of the full-width values
    assign slope_wide     = {{(WIDE-RW){r_out_slope[RW-1]}}, r_out_slope};
    assign curv_wide      = {{(WIDE-CW){r_out_curv[CW-1]}}, r_out_curv};
    assign o_valid        = r_out_valid;
    assign o_slope        = slope_wide[SLOPE_W-1:0];
    assign o_curvature_x2 = curv_wide[CURV_W-1:0];
    assign o_final_result = r_out_final;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid register filled without a stalled output");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && is_final) |=> (r_seen == '0 && r_flush == FLUSH_IDLE))
        else $error("state not cleared after the final flush step");

endmodule

### tb/pdzc_checker.sv
// checker for profile_derivative_zero_crossing_unit: watches both channels,
// predicts slope, curvature and final flag per sample and compares in order
// depends on rtl/pdzc_pkg.sv

module pdzc_checker
    import pdzc_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_is_last,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [SLOPE_W-1:0]     i_slope,
    input  logic signed [CURV_W-1:0]      i_curvature_x2,
    input  logic                          i_final_result,
    output int                            o_errors,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [SLOPE_W-1:0]     t_slope;
    typedef logic signed [CURV_W-1:0]      t_curv;

    typedef struct packed {
        t_slope slope;
        t_curv  curv;
        logic   last_flag;
    } t_derivative;

    // windows hold exact values, outputs keep only their low bits
    longint      win_sample [3];
    longint      win_raw    [3];
    longint      win_cur    [3];
    logic        win_cross  [3];
    longint      win_curv   [3];
    logic [1:0]  seen;

    t_derivative pending_derivatives [$];

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void clear_windows();
        for (int k = 0; k < 3; k++) begin
            win_sample[k] = 0;
            win_raw[k]    = 0;
            win_cur[k]    = 0;
            win_cross[k]  = 1'b0;
            win_curv[k]   = 0;
        end
        seen = '0;
    endfunction

    // move the window one sample on; the index three places back leaves
    function automatic void shift_profile_window(input longint s, input bit cross_ok,
                                                 input bit last_out);
        longint      new_raw;
        longint      new_curv;
        bit          emit;
        bit          new_cross;
        t_derivative d;
        new_raw  = win_sample[1] - s;
        new_curv = win_sample[1] - 2 * win_sample[0] + s;
        emit     = (seen == SEEN_FULL);

        win_raw[2]  = win_raw[1];
        win_raw[1]  = win_raw[0];
        win_raw[0]  = new_raw;
        win_cur[2]  = win_cur[1];
        win_cur[1]  = win_cur[0];
        win_cur[0]  = new_raw;
        win_curv[2] = win_curv[1];
        win_curv[1] = win_curv[0];
        win_curv[0] = new_curv;

        new_cross = cross_ok && emit && ((win_raw[2] > 0) != (win_raw[0] > 0));
        win_cross[2] = win_cross[1];
        win_cross[1] = win_cross[0];
        win_cross[0] = new_cross;

        // two neighboring crossings: the weaker slope goes to zero, the later on a tie
        if (win_cross[1] && win_cross[0]) begin
            if (magnitude(win_cur[2]) < magnitude(win_cur[1]))
                win_cur[2] = 0;
            else
                win_cur[1] = 0;
        end

        win_sample[2] = win_sample[1];
        win_sample[1] = win_sample[0];
        win_sample[0] = s;

        if (seen != SEEN_FULL)
            seen = seen + 2'd1;

        if (emit) begin
            d.slope     = t_slope'(win_cur[2]);
            d.curv      = t_curv'(win_curv[2]);
            d.last_flag = last_out;
            pending_derivatives = {pending_derivatives, d};
        end
    endfunction

    function automatic void report_field(input string field, input logic signed [31:0] want,
                                         input logic signed [31:0] have);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, have);
        o_errors++;
    endfunction

    always @(posedge i_clk) begin
        t_derivative want;
        if (!i_rst_n) begin
            clear_windows();
            pending_derivatives.delete();
            o_errors = 0;
        end else begin
            if (i_in_valid && !i_in_stall) begin
                shift_profile_window(longint'(i_sample), 1'b1, 1'b0);
                // last sample: three zero samples flush the pending indices
                if (i_is_last) begin
                    shift_profile_window(0, 1'b1, 1'b0);
                    shift_profile_window(0, 1'b0, 1'b0);
                    shift_profile_window(0, 1'b0, 1'b1);
                    clear_windows();
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_derivatives.size() == 0) begin
                    $display("%0t: result with none expected, slope %0d curvature %0d final %0b",
                             $time, i_slope, i_curvature_x2, i_final_result);
                    o_errors++;
                end else begin
                    want = pending_derivatives.pop_front();
                    if (i_slope !== want.slope)
                        report_field("slope", want.slope, i_slope);
                    if (i_curvature_x2 !== want.curv)
                        report_field("curvature_x2", want.curv, i_curvature_x2);
                    if (i_final_result !== want.last_flag)
                        report_field("final_result", {31'd0, want.last_flag},
                                     {31'd0, i_final_result});
                end
            end
        end
        o_pending = pending_derivatives.size();
    end

endmodule

### tb/tb_top.sv
// top of the profile_derivative_zero_crossing_unit testbench: clock, reset,
// sample sequences with bursty valid, receiver stall patterns and the verdict
// depends on rtl/pdzc_pkg.sv, the unit itself and tb/pdzc_checker.sv

module tb_top
    import pdzc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS  = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 16;

    localparam int STALL_NONE    = 0;
    localparam int STALL_HALF    = 1;
    localparam int STALL_HEAVY   = 2;
    localparam int STALL_EVERY_3 = 3;
    localparam int STALL_SOLID   = 4;

    localparam int VALUES_SMALL   = 0;
    localparam int VALUES_FULL    = 1;
    localparam int VALUES_WALK    = 2;
    localparam int VALUES_EXTREME = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_valid        = 1'b0;
    t_sample                   i_sample       = '0;
    logic                      i_is_last      = 1'b0;
    logic                      i_stall        = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic signed [SLOPE_W-1:0] o_slope;
    logic signed [CURV_W-1:0]  o_curvature_x2;
    logic                      o_final_result;

    int   errors;
    int   pending;
    logic in_taken    = 1'b0;
    int   idle_cycles = 0;
    int   burst_left  = 0;
    int   profile_q [$];

    profile_derivative_zero_crossing_unit #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_slope       (o_slope),
        .o_curvature_x2(o_curvature_x2),
        .o_final_result(o_final_result)
    );

    pdzc_checker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_sample      (i_sample),
        .i_is_last     (i_is_last),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_slope       (o_slope),
        .i_curvature_x2(o_curvature_x2),
        .i_final_result(o_final_result),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always #10 i_clk = ~i_clk;

    // transaction tracking for the sender, plus the idle watchdog
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver back-pressure, switching between patterns
    always @(negedge i_clk) begin
        int stall_mode;
        int mode_left;
        int phase;
        if (mode_left <= 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_SOLID);
            mode_left  = $urandom_range(8, 40);
        end
        mode_left--;
        phase++;
        case (stall_mode)
            STALL_NONE:    i_stall <= 1'b0;
            STALL_HALF:    i_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY:   i_stall <= ($urandom_range(0, 3) != 0);
            STALL_EVERY_3: i_stall <= (phase % 3 == 0);
            default:       i_stall <= 1'b1;
        endcase
    end

    task automatic send_sample(input t_sample value, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_sample  <= value;
        i_is_last <= last;
        do @(negedge i_clk); while (!in_taken);
    endtask

    task automatic send_profile();
        for (int k = 0; k < profile_q.size(); k++)
            send_sample(t_sample'(profile_q[k]), k == profile_q.size() - 1);
    endtask

    function automatic int random_value(input int mode, input int prev);
        int v;
        case (mode)
            VALUES_SMALL: v = $urandom_range(0, 6) - 3;
            VALUES_FULL:  v = t_sample'($urandom());
            VALUES_WALK: begin
                v = prev + $urandom_range(0, 4000) - 2000;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        int sent;
        int pick;
        int len;
        int mode;
        int v;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-sample sequences at both extremes
        profile_q = '{32767};
        send_profile();
        profile_q = '{-32768};
        send_profile();
        // two samples, no interior index
        profile_q = '{32767, -32768};
        send_profile();
        // alternating extremes
        profile_q = '{-32768, 32767, -32768, 32767, -32768};
        send_profile();
        // adjacent crossings with equal slope magnitudes
        profile_q = '{4, 4, 0, 0, 4, 4, 0};
        send_profile();
        // adjacent crossings, unequal magnitudes
        profile_q = '{6, 3, 0, 0, 4, 6};
        send_profile();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                len = 1;
            else if (pick <= 6)
                len = $urandom_range(2, 10);
            else if (pick <= 8)
                len = $urandom_range(11, 24);
            else
                len = $urandom_range(2, 3);
            mode = $urandom_range(VALUES_SMALL, VALUES_EXTREME);
            profile_q.delete();
            v = 0;
            for (int k = 0; k < len; k++) begin
                v = random_value(mode, v);
                profile_q = {profile_q, v};
            end
            send_profile();
            sent += len;
        end
        i_valid <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
